// ----- rtl/core/iau_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval arithmetic unit package
// Command codes, status codes and sequencer states shared by the unit.
// ----------------------------------------------------------------------------
package iau_pkg;

    // Command carried in the input tuser field.
    typedef enum logic [3:0] {
        ACT_ENTER     = 4'd0,
        ACT_NEGATE    = 4'd1,
        ACT_INVERT    = 4'd2,
        ACT_STORE     = 4'd3,
        ACT_RECALL    = 4'd4,
        ACT_MEMCLEAR  = 4'd5,
        ACT_MEMADD    = 4'd6,
        ACT_MEMSUB    = 4'd7,
        ACT_ADD       = 4'd8,
        ACT_SUB       = 4'd9,
        ACT_MUL       = 4'd10,
        ACT_DIV       = 4'd11,
        ACT_DIVIDEDBY = 4'd12,
        ACT_INTERSECT = 4'd13
    } iau_action_t;

    // Status reported with each result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_SAT      = 2'd3
    } iau_status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD,
        S_RUN,
        S_POST,
        S_FINISH
    } iau_state_t;

endpackage

// ----- rtl/core/interval_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// Interval arithmetic unit
// Current and memory intervals in signed fixed point with a bit-serial
// multiply and divide unit shared by all product and quotient commands.
// ----------------------------------------------------------------------------
// One command is taken per beat and answered with exactly one result beat.
// Add, subtract, negate, memory and intersect commands finish in the decide
// state and pass straight to the finish state. Multiply and divide run their
// four products or quotients one after another through a single bit-serial
// unit that retires one bit per cycle, and invert or dividedby run two
// quotients; each product or quotient passes the load, run and post states.
// A new command is taken while the previous result still waits on the
// output register.
module interval_arithmetic_unit_top
    import iau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: operand_lo, operand_hi, zero fill.
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]       s_tdata,
    // Fields from bit 0: action.
    input  logic [3:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: result_lo, result_hi, zero fill.
    output logic [((2*WORD_BITS+7)/8)*8-1:0]       m_tdata,
    // Fields from bit 0: result_empty, status.
    output logic [2:0]                             m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int NW  = WORD_BITS + FRAC_BITS;
    localparam int VW  = 2 * WORD_BITS + 2;
    localparam int CW  = $clog2(NW + 1);
    localparam int TDW = ((2 * WORD_BITS + 7) / 8) * 8;

    localparam logic signed [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [VW-1:0] MAX_EXT = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN_EXT = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Saturating add or subtract; the top bit flags a clamp.
    function automatic logic [W:0] add_sat(logic signed [W-1:0] a,
                                           logic signed [W-1:0] b, logic sub);
        logic signed [W:0] s;
        logic [W:0]        r;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            r = {1'b1, (s[W] ? MIN_W : MAX_W)};
        end else begin
            r = {1'b0, s[W-1:0]};
        end
        return r;
    endfunction

    // Magnitude as an unsigned word; the most negative value fits.
    function automatic logic [W-1:0] mag(logic signed [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    iau_state_t          state_reg, state_next;
    iau_action_t         act_reg, act_next;
    logic signed [W-1:0] c_reg, c_next, d_reg, d_next;
    logic signed [W-1:0] cur_lo_reg, cur_lo_next, cur_hi_reg, cur_hi_next;
    logic                cur_empty_reg, cur_empty_next;
    logic signed [W-1:0] mem_lo_reg, mem_lo_next, mem_hi_reg, mem_hi_next;
    logic                mem_empty_reg, mem_empty_next;
    iau_status_t         status_reg, status_next;
    logic                sat_reg, sat_next;
    logic [1:0]          idx_reg, idx_next;
    logic signed [W-1:0] run_lo_reg, run_lo_next, run_hi_reg, run_hi_next;
    logic [2*W-1:0]      acc_reg, acc_next, mcand_reg, mcand_next;
    logic [W-1:0]        mplier_reg, mplier_next;
    logic [W-1:0]        rem_reg, rem_next, dvs_reg, dvs_next;
    logic [NW-1:0]       nq_reg, nq_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next, last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic [TDW-1:0]      m_data_reg, m_data_next;
    logic [2:0]          m_user_reg, m_user_next;

    // Combinational helpers.
    logic                is_mul, needs_valid, straddle, last_job;
    logic signed [W-1:0] pa, pb;
    logic [W:0]          r0, r1, shifted;
    logic signed [VW-1:0] val, sp;
    logic [VW-1:0]       qq;
    logic signed [W-1:0] sv, lo_t, hi_t;
    logic                sv_flag;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Operand pair for the current job of a multi-step command.
    always_comb begin
        is_mul   = (act_reg == ACT_MUL);
        straddle = (cur_lo_reg <= 0) && (cur_hi_reg >= 0);
        last_job = (act_reg == ACT_MUL || act_reg == ACT_DIV) ? (idx_reg == 2'd3)
                                                              : (idx_reg == 2'd1);
        pa = cur_lo_reg;
        pb = c_reg;
        case (act_reg)
            ACT_INVERT: begin
                pa = ONE_W;
                pb = idx_reg[0] ? cur_lo_reg : cur_hi_reg;
            end
            ACT_DIVIDEDBY: begin
                pa = c_reg;
                pb = idx_reg[0] ? cur_hi_reg : cur_lo_reg;
            end
            default: begin
                pa = idx_reg[1] ? cur_hi_reg : cur_lo_reg;
                pb = idx_reg[0] ? d_reg : c_reg;
            end
        endcase
    end

    // Scale and saturate the finished product or quotient.
    always_comb begin
        sp  = neg_reg ? -$signed({2'b00, acc_reg}) : $signed({2'b00, acc_reg});
        qq  = VW'(nq_reg) + VW'(rem_reg != '0);
        val = is_mul ? (sp >>> FRAC_BITS) : (neg_reg ? -$signed(qq) : $signed(VW'(nq_reg)));
        if (val > MAX_EXT) begin
            sv = MAX_W;
            sv_flag = 1'b1;
        end else if (val < MIN_EXT) begin
            sv = MIN_W;
            sv_flag = 1'b1;
        end else begin
            sv = val[W-1:0];
            sv_flag = 1'b0;
        end
        lo_t = (idx_reg == 2'd0 || sv < run_lo_reg) ? sv : run_lo_reg;
        hi_t = (idx_reg == 2'd0 || sv > run_hi_reg) ? sv : run_hi_reg;
        shifted = {rem_reg, nq_reg[NW-1]};
    end

    // Sequencer and datapath next state.
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;
        cur_empty_next = cur_empty_reg;
        mem_lo_next    = mem_lo_reg;
        mem_hi_next    = mem_hi_reg;
        mem_empty_next = mem_empty_reg;
        status_next    = status_reg;
        sat_next       = sat_reg;
        idx_next       = idx_reg;
        run_lo_next    = run_lo_reg;
        run_hi_next    = run_hi_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        nq_next        = nq_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        needs_valid    = (act_reg == ACT_ENTER) || (act_reg == ACT_ADD) ||
                         (act_reg == ACT_SUB) || (act_reg == ACT_MUL) ||
                         (act_reg == ACT_DIV) || (act_reg == ACT_INTERSECT);
        r0 = '0;
        r1 = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = iau_action_t'(s_tuser);
                    c_next     = s_tdata[W-1:0];
                    d_next     = s_tdata[2*W-1:W];
                    state_next = S_DECIDE;
                end
            end

            // Commands that need no product or quotient finish here; the rest start the serial unit.
            S_DECIDE: begin
                status_next = ST_OK;
                sat_next    = 1'b0;
                idx_next    = 2'd0;
                state_next  = S_FINISH;
                if (needs_valid && c_reg > d_reg) begin
                    status_next = ST_INVALID;
                end else begin
                    case (act_reg)
                        ACT_ENTER: begin
                            cur_lo_next    = c_reg;
                            cur_hi_next    = d_reg;
                            cur_empty_next = 1'b0;
                        end
                        ACT_NEGATE: begin
                            if (!cur_empty_reg) begin
                                r0 = add_sat('0, cur_hi_reg, 1'b1);
                                r1 = add_sat('0, cur_lo_reg, 1'b1);
                            end
                        end
                        ACT_INVERT, ACT_DIVIDEDBY: begin
                            if (!cur_empty_reg) begin
                                if (straddle) begin
                                    status_next = ST_DIV_ZERO;
                                end else begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        ACT_STORE: begin
                            if (!cur_empty_reg) begin
                                mem_lo_next    = cur_lo_reg;
                                mem_hi_next    = cur_hi_reg;
                                mem_empty_next = 1'b0;
                            end
                        end
                        ACT_RECALL: begin
                            if (!mem_empty_reg) begin
                                cur_lo_next    = mem_lo_reg;
                                cur_hi_next    = mem_hi_reg;
                                cur_empty_next = 1'b0;
                            end
                        end
                        ACT_MEMCLEAR: begin
                            mem_lo_next    = '0;
                            mem_hi_next    = '0;
                            mem_empty_next = 1'b1;
                        end
                        ACT_MEMADD, ACT_MEMSUB: begin
                            if (!mem_empty_reg && !cur_empty_reg) begin
                                if (act_reg == ACT_MEMADD) begin
                                    r0 = add_sat(mem_lo_reg, cur_lo_reg, 1'b0);
                                    r1 = add_sat(mem_hi_reg, cur_hi_reg, 1'b0);
                                end else begin
                                    r0 = add_sat(mem_lo_reg, cur_hi_reg, 1'b1);
                                    r1 = add_sat(mem_hi_reg, cur_lo_reg, 1'b1);
                                end
                                mem_lo_next = r0[W-1:0];
                                mem_hi_next = r1[W-1:0];
                            end
                        end
                        ACT_ADD, ACT_SUB: begin
                            if (!cur_empty_reg) begin
                                if (act_reg == ACT_ADD) begin
                                    r0 = add_sat(cur_lo_reg, c_reg, 1'b0);
                                    r1 = add_sat(cur_hi_reg, d_reg, 1'b0);
                                end else begin
                                    r0 = add_sat(cur_lo_reg, d_reg, 1'b1);
                                    r1 = add_sat(cur_hi_reg, c_reg, 1'b1);
                                end
                            end
                        end
                        ACT_MUL: begin
                            if (!cur_empty_reg) begin
                                state_next = S_LOAD;
                            end
                        end
                        ACT_DIV: begin
                            if (!cur_empty_reg) begin
                                if (c_reg <= 0 && d_reg >= 0) begin
                                    status_next = ST_DIV_ZERO;
                                end else begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        ACT_INTERSECT: begin
                            if (!cur_empty_reg) begin
                                if (d_reg < cur_lo_reg || c_reg > cur_hi_reg) begin
                                    cur_empty_next = 1'b1;
                                    cur_lo_next    = '0;
                                    cur_hi_next    = '0;
                                end else begin
                                    if (c_reg > cur_lo_reg) cur_lo_next = c_reg;
                                    if (d_reg < cur_hi_reg) cur_hi_next = d_reg;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Bounds from the add and negate paths.
                    if (!cur_empty_reg && (act_reg == ACT_NEGATE ||
                        act_reg == ACT_ADD || act_reg == ACT_SUB)) begin
                        cur_lo_next = r0[W-1:0];
                        cur_hi_next = r1[W-1:0];
                    end
                    if (r0[W] || r1[W]) begin
                        status_next = ST_SAT;
                    end
                    // A zero-straddling divisor clears the current interval.
                    if ((act_reg == ACT_INVERT || act_reg == ACT_DIVIDEDBY) &&
                        !cur_empty_reg && straddle) begin
                        cur_empty_next = 1'b1;
                        cur_lo_next    = '0;
                        cur_hi_next    = '0;
                    end
                    if (act_reg == ACT_DIV && !cur_empty_reg && c_reg <= 0 && d_reg >= 0) begin
                        cur_empty_next = 1'b1;
                        cur_lo_next    = '0;
                        cur_hi_next    = '0;
                    end
                end
            end

            // Set up the serial unit for one product or quotient.
            S_LOAD: begin
                neg_next = pa[W-1] ^ pb[W-1];
                cnt_next = '0;
                if (is_mul) begin
                    acc_next    = '0;
                    mcand_next  = {{W{1'b0}}, mag(pa)};
                    mplier_next = mag(pb);
                    last_next   = CW'(W - 1);
                end else begin
                    nq_next   = NW'(mag(pa)) << FRAC_BITS;
                    rem_next  = '0;
                    dvs_next  = mag(pb);
                    last_next = CW'(NW - 1);
                end
                state_next = S_RUN;
            end

            // One multiplier or quotient bit per cycle.
            S_RUN: begin
                if (is_mul) begin
                    if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end else begin
                    if (shifted >= {1'b0, dvs_reg}) begin
                        rem_next = W'(shifted - {1'b0, dvs_reg});
                        nq_next  = {nq_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_next = shifted[W-1:0];
                        nq_next  = {nq_reg[NW-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_reg) begin
                    state_next = S_POST;
                end
            end

            // Fold the job result into the running minimum and maximum.
            S_POST: begin
                run_lo_next = lo_t;
                run_hi_next = hi_t;
                sat_next    = sat_reg | sv_flag;
                if (last_job) begin
                    cur_lo_next = lo_t;
                    cur_hi_next = hi_t;
                    status_next = (sat_reg | sv_flag) ? ST_SAT : ST_OK;
                    state_next  = S_FINISH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end

            // Hand the result to the output register once it is free.
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = TDW'({cur_hi_reg, cur_lo_reg});
                    m_user_next  = {status_reg, cur_empty_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_lo_reg    <= '0;
            cur_hi_reg    <= '0;
            cur_empty_reg <= 1'b1;
            mem_lo_reg    <= '0;
            mem_hi_reg    <= '0;
            mem_empty_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_lo_reg    <= cur_lo_next;
            cur_hi_reg    <= cur_hi_next;
            cur_empty_reg <= cur_empty_next;
            mem_lo_reg    <= mem_lo_next;
            mem_hi_reg    <= mem_hi_next;
            mem_empty_reg <= mem_empty_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
        idx_reg    <= idx_next;
        run_lo_reg <= run_lo_next;
        run_hi_reg <= run_hi_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        nq_reg     <= nq_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

// ----- rtl/core/iau_checker.sv -----
// ----------------------------------------------------------------------------
// Interval arithmetic unit checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module iau_port_asserts #(
    parameter int WORD_BITS = 32
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic [2:0]                       m_tuser
);

    localparam int W = WORD_BITS;

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // An empty interval always shows zero bounds.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[2*W-1:0] == '0))
        else $error("empty interval with nonzero bounds");

    // A filled interval keeps its lower bound at or below its upper bound.
    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            ($signed(m_tdata[W-1:0]) <= $signed(m_tdata[2*W-1:W])))
        else $error("result bounds out of order");

    // No result beat leaves straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind interval_arithmetic_unit_top iau_port_asserts #(.WORD_BITS(WORD_BITS)) u_iau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/iau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval arithmetic unit checker
// Watches both stream channels, predicts the result of each accepted command
// beat from its own copy of the current and memory intervals, and compares
// every accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module iau_checker
    import iau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    localparam longint MAX_VAL = 64'sd2147483647;
    localparam longint MIN_VAL = -64'sd2147483648;
    localparam longint Q_ONE   = 64'sd65536;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        empty;
        iau_status_t status;
    } interval_result_t;

    interval_result_t result_queue[$];

    // Shadow copy of the unit's state.
    longint cur_lo, cur_hi, mem_lo, mem_hi;
    bit     cur_empty, mem_empty;
    bit     clamped;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        cur_lo = 0; cur_hi = 0; cur_empty = 1;
        mem_lo = 0; mem_hi = 0; mem_empty = 1;
    end

    function automatic longint clamp_word(longint v);
        if (v > MAX_VAL) begin
            clamped = 1;
            return MAX_VAL;
        end
        if (v < MIN_VAL) begin
            clamped = 1;
            return MIN_VAL;
        end
        return v;
    endfunction

    // Division rounded toward minus infinity.
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return clamp_word(floor_div(a * b, Q_ONE));
    endfunction

    function automatic longint q_quo(longint a, longint b);
        return clamp_word(floor_div(a * Q_ONE, b));
    endfunction

    function automatic longint min2(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint max2(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic void clear_current();
        cur_lo = 0;
        cur_hi = 0;
        cur_empty = 1;
    endfunction

    // Applies one command to the shadow state and returns the expected beat.
    function automatic interval_result_t apply_command(logic [3:0] act, logic [31:0] op_lo,
                                                       logic [31:0] op_hi);
        interval_result_t r;
        longint c, d, p0, p1, p2, p3, t0, t1;
        bit checks_operand;
        iau_status_t st;
        c  = longint'($signed(op_lo));
        d  = longint'($signed(op_hi));
        st = ST_OK;
        clamped = 0;
        checks_operand = (act == ACT_ENTER) || (act == ACT_ADD) || (act == ACT_SUB) ||
                         (act == ACT_MUL) || (act == ACT_DIV) || (act == ACT_INTERSECT);
        if (checks_operand && c > d) begin
            st = ST_INVALID;
        end else begin
            case (act)
                ACT_ENTER: begin
                    cur_lo = c; cur_hi = d; cur_empty = 0;
                end
                ACT_NEGATE: if (!cur_empty) begin
                    t0 = clamp_word(-cur_hi); t1 = clamp_word(-cur_lo);
                    cur_lo = t0; cur_hi = t1;
                end
                ACT_INVERT: if (!cur_empty) begin
                    if (cur_lo <= 0 && cur_hi >= 0) begin
                        clear_current(); st = ST_DIV_ZERO;
                    end else begin
                        t0 = q_quo(Q_ONE, cur_hi); t1 = q_quo(Q_ONE, cur_lo);
                        cur_lo = min2(t0, t1); cur_hi = max2(t0, t1);
                    end
                end
                ACT_STORE: if (!cur_empty) begin
                    mem_lo = cur_lo; mem_hi = cur_hi; mem_empty = 0;
                end
                ACT_RECALL: if (!mem_empty) begin
                    cur_lo = mem_lo; cur_hi = mem_hi; cur_empty = 0;
                end
                ACT_MEMCLEAR: begin
                    mem_lo = 0; mem_hi = 0; mem_empty = 1;
                end
                ACT_MEMADD: if (!mem_empty && !cur_empty) begin
                    mem_lo = clamp_word(mem_lo + cur_lo);
                    mem_hi = clamp_word(mem_hi + cur_hi);
                end
                ACT_MEMSUB: if (!mem_empty && !cur_empty) begin
                    t0 = clamp_word(mem_lo - cur_hi);
                    t1 = clamp_word(mem_hi - cur_lo);
                    mem_lo = t0; mem_hi = t1;
                end
                ACT_ADD: if (!cur_empty) begin
                    cur_lo = clamp_word(cur_lo + c); cur_hi = clamp_word(cur_hi + d);
                end
                ACT_SUB: if (!cur_empty) begin
                    t0 = clamp_word(cur_lo - d); t1 = clamp_word(cur_hi - c);
                    cur_lo = t0; cur_hi = t1;
                end
                ACT_MUL: if (!cur_empty) begin
                    p0 = q_mul(cur_lo, c); p1 = q_mul(cur_lo, d);
                    p2 = q_mul(cur_hi, c); p3 = q_mul(cur_hi, d);
                    cur_lo = min2(min2(p0, p1), min2(p2, p3));
                    cur_hi = max2(max2(p0, p1), max2(p2, p3));
                end
                ACT_DIV: if (!cur_empty) begin
                    if (c <= 0 && d >= 0) begin
                        clear_current(); st = ST_DIV_ZERO;
                    end else begin
                        p0 = q_quo(cur_lo, c); p1 = q_quo(cur_lo, d);
                        p2 = q_quo(cur_hi, c); p3 = q_quo(cur_hi, d);
                        cur_lo = min2(min2(p0, p1), min2(p2, p3));
                        cur_hi = max2(max2(p0, p1), max2(p2, p3));
                    end
                end
                ACT_DIVIDEDBY: if (!cur_empty) begin
                    if (cur_lo <= 0 && cur_hi >= 0) begin
                        clear_current(); st = ST_DIV_ZERO;
                    end else begin
                        t0 = q_quo(c, cur_lo); t1 = q_quo(c, cur_hi);
                        cur_lo = min2(t0, t1); cur_hi = max2(t0, t1);
                    end
                end
                ACT_INTERSECT: if (!cur_empty) begin
                    if (d < cur_lo || c > cur_hi) begin
                        clear_current();
                    end else begin
                        cur_lo = max2(cur_lo, c); cur_hi = min2(cur_hi, d);
                    end
                end
                default: ;
            endcase
        end
        if (st == ST_OK && clamped)
            st = ST_SAT;
        r.lo     = cur_lo[31:0];
        r.hi     = cur_hi[31:0];
        r.empty  = cur_empty;
        r.status = st;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s in result %0d: got %h, expected %h",
                 $realtime, what, results_seen, got, want);
        fail_count++;
    endtask

    // Prediction on command beats, comparison on result beats.
    always @(posedge aclk) begin
        interval_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                result_queue.push_back(apply_command(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: result beat with no command waiting", $realtime);
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata[31:0] !== want.lo)
                        report_mismatch("result_lo", m_tdata[31:0], want.lo);
                    if (m_tdata[63:32] !== want.hi)
                        report_mismatch("result_hi", m_tdata[63:32], want.hi);
                    if (m_tuser[0] !== want.empty)
                        report_mismatch("result_empty", m_tuser[0], want.empty);
                    if (m_tuser[2:1] !== want.status)
                        report_mismatch("status", m_tuser[2:1], want.status);
                end
                results_seen++;
            end
            pending = result_queue.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval arithmetic unit testbench
// Drives directed and random command beats in bursts, stalls the result
// channel on its own pattern, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import iau_pkg::*;

    localparam int RANDOM_COMMANDS = 1100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // Fields from bit 0: operand_lo, operand_hi.
    logic [63:0] s_tdata = '0;
    // Fields from bit 0: action.
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // Fields from bit 0: result_lo, result_hi.
    logic [63:0] m_tdata;
    // Fields from bit 0: result_empty, status.
    logic [2:0]  m_tuser;

    int fail_count, pending, results_seen;
    int burst_left = 0;
    bit hold_request = 0;
    int long_holds = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    interval_arithmetic_unit_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    iau_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // Result side: stall pattern that changes mode, plus long hold-offs on request.
    always @(posedge aclk) begin
        int hold_left;
        int mode_left;
        int mode;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
            mode = 0;
        end else begin
            if (hold_request) begin
                hold_request = 0;
                hold_left = 400;
                long_holds++;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= ($urandom_range(0, 9) < 2);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Offers one command beat and returns at the edge that accepts it.
    task automatic send_command(logic [3:0] act, logic [31:0] lo, logic [31:0] hi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0 && s_tvalid) begin
                s_tvalid <= 1'b0;
            end
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hi, lo};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] a, b, t;
        logic [3:0]  act;
        a = pick_bound();
        b = pick_bound();
        // Mostly well-ordered operands so that commands get past the operand check.
        if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
            t = a; a = b; b = t;
        end
        if ($urandom_range(0, 6) == 0)
            act = ACT_ENTER;
        else
            act = 4'($urandom_range(0, 15));
        if (act == ACT_DIVIDEDBY && $urandom_range(0, 1))
            b = $urandom;
        send_command(act, a, b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commands on an empty unit, then the invalid operand check.
        send_command(ACT_RECALL, 32'h1234_5678, 32'h0);
        send_command(ACT_NEGATE, 32'h0, 32'h0);
        send_command(ACT_STORE, 32'h0, 32'h0);
        send_command(ACT_INVERT, 32'h0, 32'h0);
        send_command(ACT_MEMADD, 32'h0, 32'h0);
        send_command(ACT_ENTER, 32'h0001_0000, 32'h0000_0000);
        send_command(ACT_ADD, 32'h0000_0001, 32'h0000_0000);
        // Saturation at both ends of the word range.
        send_command(ACT_ENTER, 32'h8000_0000, 32'h7fff_ffff);
        send_command(ACT_NEGATE, 32'h0, 32'h0);
        send_command(ACT_STORE, 32'h0, 32'h0);
        send_command(ACT_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
        send_command(ACT_MEMADD, 32'h0, 32'h0);
        send_command(ACT_MEMSUB, 32'hffff_ffff, 32'hffff_ffff);
        send_command(ACT_RECALL, 32'h0, 32'h0);
        send_command(ACT_MUL, 32'h8000_0000, 32'h7fff_ffff);
        // Zero divisors, then ordinary quotients.
        send_command(ACT_ENTER, 32'hffff_0000, 32'h0001_0000);
        send_command(ACT_INVERT, 32'h0, 32'h0);
        send_command(ACT_ENTER, 32'h0002_0000, 32'h0004_0000);
        send_command(ACT_INVERT, 32'h0, 32'h0);
        send_command(ACT_DIV, 32'hffff_0000, 32'h0000_0000);
        send_command(ACT_ENTER, 32'hfffd_0000, 32'hffff_8000);
        send_command(ACT_DIV, 32'h0002_0000, 32'h0005_0000);
        send_command(ACT_DIVIDEDBY, 32'h0007_0000, 32'h0);
        send_command(ACT_SUB, 32'hffff_0000, 32'h0003_0000);
        // Overlapping, then disjoint intersect, unused codes and memory clear.
        send_command(ACT_INTERSECT, 32'hffff_0000, 32'h0001_0000);
        send_command(ACT_INTERSECT, 32'h7000_0000, 32'h7fff_ffff);
        send_command(ACT_MEMCLEAR, 32'h0, 32'h0);
        send_command(4'd14, 32'hffff_ffff, 32'h0);
        send_command(4'd15, 32'h0, 32'hffff_ffff);

        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            if (n == 300)
                hold_request = 1;
            if (n == 700)
                wait_drained();
            send_random();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Ran directed and %0d random commands, %0d results checked, %0d long hold-offs.",
                 RANDOM_COMMANDS, results_seen, long_holds);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog well above the slowest legal run.
    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding.", pending);
        $display("simulation failed");
        $finish;
    end

endmodule
